>>> sv/gmpu_pkg.sv
package gmpu_pkg;

  // Entry store geometry
  localparam int ELEMENTS = 4096;
  localparam int ELEM_AW  = (ELEMENTS > 2) ? $clog2(ELEMENTS) : 1;

  // Field widths
  localparam int IDX_W     = 12;
  localparam int POS_W     = 32;
  localparam int GAIN_W    = 24;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int ENTRY_W   = 2 * POS_W + GAIN_W;
  localparam int RANGE_W   = ((ELEM_AW > IDX_W) ? ELEM_AW : IDX_W) + 1;

  // Gain arithmetic, unsigned Q8.16
  localparam logic [GAIN_W-1:0] GAIN_ONE   = 24'd65536;
  localparam logic [GAIN_W-1:0] GAIN_ADD   = 24'd13107;
  localparam logic [GAIN_W-1:0] GAIN_FLOOR = 24'd655;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 24'hFF_FFFF;
  localparam logic [15:0]       GAIN_MUL   = 16'd52429;

  // Register reset values
  localparam logic [CFG_W-1:0] MOMENTUM_RST = 16'd32768;
  localparam logic [CFG_W-1:0] LRATE_RST    = 16'd51200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOMENTUM      = 1'b0,
    REG_LEARNING_RATE = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_APPLY = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EG,
    ST_MOM,
    ST_STEP,
    ST_VEL,
    ST_POS,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic signed [POS_W-1:0] vel;
    logic [GAIN_W-1:0]       gain;
  } entry_t;

endpackage

>>> sv/gmpu_ram.sv
module gmpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/gain_momentum_position_update.sv
// An apply item goes from READ through the EG, MOM, STEP, VEL and POS states to DONE;
// a load item or an out-of-range index goes straight to DONE.
// Items are taken one at a time: the input stalls until DONE has handed the result to
// the output register, as the entry read-modify-write walks the multiply steps below.
// Reset (rst_n, synchronous): idle, output empty, registers at 0.5 / 200.0;
// entry memory contents stay undefined (no clearing pass).
module gain_momentum_position_update
  import gmpu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // item input
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_op,
  input  logic [IDX_W-1:0]         in_element_index,
  input  logic signed [POS_W-1:0]  in_operand_value,
  // result output
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [POS_W-1:0]  out_new_position,
  output logic [GAIN_W-1:0]        out_new_gain,
  output logic                     out_saturated,
  // configuration
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  localparam logic signed [49:0] VEL_MAX = 50'sd2147483647;
  localparam logic signed [49:0] VEL_MIN = -50'sd2147483648;
  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic [CFG_W-1:0] momentum_r;
  logic [CFG_W-1:0] lrate_r;

  logic in_xfer;
  logic out_load;
  logic ram_re;
  logic ram_we;
  logic in_range;

  // ---------------------------------------------------------------------------
  // Item and datapath registers
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0]        idx_r;
  logic                    in_range_r;
  logic                    val_zero_r;
  logic                    val_neg_r;
  logic [POS_W-1:0]        gmag_r;       // |gradient|
  logic signed [POS_W-1:0] pos_r;
  logic [POS_W-1:0]        vmag_r;       // |stored velocity|
  logic                    vel_neg_r;
  logic [GAIN_W-1:0]       gain_r;
  logic [31:0]             eg_r;         // eta * gain, unsigned Q.16
  logic signed [32:0]      mterm_r;      // momentum * velocity
  logic [63:0]             step_prod_r;  // eg * |gradient|, before rounding
  logic signed [POS_W-1:0] nv_r;
  logic                    sat_r;

  // Result and write-back staging
  logic signed [POS_W-1:0] res_pos_r;
  logic [GAIN_W-1:0]       res_gain_r;
  logic                    res_sat_r;
  logic signed [POS_W-1:0] wr_vel_r;

  // Output register
  logic                    out_valid_r;
  logic signed [POS_W-1:0] out_pos_r;
  logic [GAIN_W-1:0]       out_gain_r;
  logic                    out_sat_r;

  // ---------------------------------------------------------------------------
  // Entry memory: {position, velocity, gain} per coordinate
  // ---------------------------------------------------------------------------
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;
  entry_t             wr_entry;

  assign rd_entry = entry_t'(ram_rdata);
  assign wr_entry = '{pos: res_pos_r, vel: wr_vel_r, gain: res_gain_r};

  gmpu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ELEMENTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ELEM_AW'(idx_r)),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (ELEM_AW'(in_element_index)),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Configuration writes; an index outside the list does nothing
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      momentum_r <= MOMENTUM_RST;
      lrate_r    <= LRATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MOMENTUM:      momentum_r <= cfg_data;
        REG_LEARNING_RATE: lrate_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  assign in_range = RANGE_W'(in_element_index) < RANGE_W'(ELEMENTS);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          // Only an in-range apply needs the stored entry; everything else
          // is settled at the transfer.
          if (op_t'(in_op) == OP_APPLY && in_range) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_READ: state_nxt = ST_EG;
      ST_EG:   state_nxt = ST_MOM;
      ST_MOM:  state_nxt = ST_STEP;
      ST_STEP: state_nxt = ST_VEL;
      ST_VEL:  state_nxt = ST_POS;
      ST_POS:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_stall = 1'b1;
    ram_re   = 1'b0;
    ram_we   = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        ram_re   = in_valid;
      end
      ST_DONE: begin
        // Hand the result over once the output register is free or draining;
        // write the entry back in the same cycle.
        out_load = !out_valid_r || !out_stall;
        ram_we   = out_load && in_range_r;
      end
      default: ;
    endcase
  end

  assign in_xfer = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath, one multiply per step
  // ---------------------------------------------------------------------------
  logic                    vel_zero;
  logic                    sign_diff;
  logic [GAIN_W:0]         gain_inc;
  logic [39:0]             gain_prod;
  logic [GAIN_W-1:0]       gain_upd;
  logic [GAIN_W-1:0]       gain_new;
  logic [39:0]             eg_prod;
  logic [47:0]             mom_prod;
  logic [32:0]             mom_mag;
  logic [47:0]             step_mag;
  logic signed [49:0]      step_s;
  logic signed [49:0]      nv_wide;
  logic signed [POS_W:0]   np_wide;
  logic                    np_ovf;

  always_comb begin
    // Gain adaption: grow when the gradient sign disagrees with the velocity
    // sign, otherwise shrink, then apply the floor.
    vel_zero  = rd_entry.vel == '0;
    sign_diff = (vel_zero != val_zero_r) || (!vel_zero && (rd_entry.vel[POS_W-1] != val_neg_r));
    gain_inc  = {1'b0, rd_entry.gain} + {1'b0, GAIN_ADD};
    gain_prod = 40'(rd_entry.gain) * 40'(GAIN_MUL) + 40'd32768;
    if (sign_diff) begin
      gain_upd = gain_inc[GAIN_W] ? GAIN_MAX : gain_inc[GAIN_W-1:0];
    end else begin
      gain_upd = gain_prod[39:16];
    end
    gain_new = (gain_upd < GAIN_FLOOR) ? GAIN_FLOOR : gain_upd;

    eg_prod  = 40'(lrate_r) * 40'(gain_r) + 40'd128;

    mom_prod = 48'(vmag_r) * 48'(momentum_r) + 48'd32768;
    mom_mag  = {1'b0, mom_prod[47:16]};

    // Round the step to nearest, ties away from zero, on the magnitude.
    step_mag = step_prod_r[63:16] + 48'(step_prod_r[15]);
    step_s   = val_neg_r ? -$signed({2'b00, step_mag}) : $signed({2'b00, step_mag});
    nv_wide  = 50'(mterm_r) - step_s;

    np_wide  = 33'(pos_r) + 33'(nv_r);
    np_ovf   = np_wide[POS_W] != np_wide[POS_W-1];
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          idx_r      <= in_element_index;
          in_range_r <= in_range;
          val_zero_r <= in_operand_value == '0;
          val_neg_r  <= in_operand_value[POS_W-1];
          gmag_r     <= in_operand_value[POS_W-1] ? POS_W'(-in_operand_value)
                                                  : POS_W'(in_operand_value);
          // Load and out-of-range items finish here.
          res_pos_r  <= in_range ? in_operand_value : '0;
          res_gain_r <= in_range ? GAIN_ONE : '0;
          res_sat_r  <= 1'b0;
          wr_vel_r   <= '0;
        end
      end
      ST_READ: begin
        pos_r     <= rd_entry.pos;
        vel_neg_r <= rd_entry.vel[POS_W-1];
        vmag_r    <= rd_entry.vel[POS_W-1] ? POS_W'(-rd_entry.vel) : POS_W'(rd_entry.vel);
        gain_r    <= gain_new;
      end
      ST_EG: begin
        eg_r <= eg_prod[39:8];
      end
      ST_MOM: begin
        mterm_r <= vel_neg_r ? -$signed(mom_mag) : $signed(mom_mag);
      end
      ST_STEP: begin
        step_prod_r <= 64'(eg_r) * 64'(gmag_r);
      end
      ST_VEL: begin
        if (nv_wide > VEL_MAX) begin
          nv_r  <= POS_MAX;
          sat_r <= 1'b1;
        end else if (nv_wide < VEL_MIN) begin
          nv_r  <= POS_MIN;
          sat_r <= 1'b1;
        end else begin
          nv_r  <= POS_W'(nv_wide);
          sat_r <= 1'b0;
        end
      end
      ST_POS: begin
        if (np_ovf) begin
          res_pos_r <= np_wide[POS_W] ? POS_MIN : POS_MAX;
        end else begin
          res_pos_r <= POS_W'(np_wide);
        end
        res_sat_r  <= sat_r || np_ovf;
        res_gain_r <= gain_r;
        wr_vel_r   <= nv_r;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register: hold while stalled, drop after the transfer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos_r  <= res_pos_r;
      out_gain_r <= res_gain_r;
      out_sat_r  <= res_sat_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_position = out_pos_r;
  assign out_new_gain     = out_gain_r;
  assign out_saturated    = out_sat_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_xfer_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_READ || state_r == ST_DONE))
    else $error("accepted item did not start processing");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result appeared without completing an item");

  a_gain_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_gain_r >= GAIN_FLOOR || out_gain_r == '0))
    else $error("result gain below floor");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (in_range_r && out_load))
    else $error("entry written without an in-range item");
`endif

endmodule

>>> sim/gain_momentum_position_update_test.sv
module gain_momentum_position_update_test;
  import gmpu_pkg::*;

  // Limits of the run: cycles without any transfer before giving up, cycles
  // to let pass after the last result so late or extra results show up.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOT_N          = 16;
  localparam int MAX_PRINTS     = 50;

  // Fixed-point constants of the update, Q8.16 gain
  localparam logic [GAIN_W-1:0] K_GAIN_ONE   = 24'd65536;
  localparam logic [63:0]       K_GAIN_UP    = 64'd13107;
  localparam logic [63:0]       K_GAIN_DECAY = 64'd52429;
  localparam logic [63:0]       K_GAIN_FLOOR = 64'd655;
  localparam logic [63:0]       K_GAIN_TOP   = 64'd16777215;
  localparam logic signed [63:0] K_POS_MAX   = 64'sd2147483647;
  localparam logic signed [63:0] K_POS_MIN   = -64'sd2147483648;

  typedef struct {
    logic signed [POS_W-1:0] position;
    logic [GAIN_W-1:0]       gain;
    logic                    sat;
  } update_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_op;
  logic [IDX_W-1:0]        in_element_index;
  logic signed [POS_W-1:0] in_operand_value;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [POS_W-1:0] out_new_position;
  logic [GAIN_W-1:0]       out_new_gain;
  logic                    out_saturated;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_data;

  // Predicted entry state and register copies
  logic signed [POS_W-1:0] model_pos  [ELEMENTS];
  logic signed [POS_W-1:0] model_vel  [ELEMENTS];
  logic [GAIN_W-1:0]       model_gain [ELEMENTS];
  logic [CFG_W-1:0]        model_momentum;
  logic [CFG_W-1:0]        model_rate;

  // Which entries were loaded; applies only ever go to these
  bit               entry_loaded [ELEMENTS];
  logic [IDX_W-1:0] loaded_list[$];
  logic [IDX_W-1:0] hot_index [HOT_N];

  update_result_t pending_updates[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int err_count;
  int result_count;
  int quiet_cycles;

  gain_momentum_position_update DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_element_index (in_element_index),
    .in_operand_value (in_operand_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_new_position (out_new_position),
    .out_new_gain     (out_new_gain),
    .out_saturated    (out_saturated),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int sign3(input logic signed [63:0] x);
    return (x == 0) ? 0 : ((x < 0) ? -1 : 1);
  endfunction

  // Clip to the signed 32-bit range and raise the flag when clipped
  function automatic logic signed [63:0] clip32(input logic signed [63:0] x,
                                                inout logic sat);
    if (x > K_POS_MAX) begin
      sat = 1'b1;
      return K_POS_MAX;
    end
    if (x < K_POS_MIN) begin
      sat = 1'b1;
      return K_POS_MIN;
    end
    return x;
  endfunction

  // Advance one entry by one item and return the result it must produce
  function automatic update_result_t predict_entry_update(input op_t op,
                                                          input logic [IDX_W-1:0] idx,
                                                          input logic signed [POS_W-1:0] operand);
    update_result_t     res;
    logic signed [63:0] vel64, grad64, mterm, step, nv, np;
    logic [63:0]        g, eg, vmag, gmag, rnd;
    logic               sat;
    sat = 1'b0;
    if (op == OP_LOAD) begin
      model_pos[idx]  = operand;
      model_vel[idx]  = '0;
      model_gain[idx] = K_GAIN_ONE;
    end else begin
      vel64  = model_vel[idx];
      grad64 = operand;
      g      = {40'd0, model_gain[idx]};
      // Grow the gain when gradient and velocity disagree, decay it otherwise
      if (sign3(grad64) != sign3(vel64)) begin
        g = g + K_GAIN_UP;
        if (g > K_GAIN_TOP) g = K_GAIN_TOP;
      end else begin
        g = (g * K_GAIN_DECAY + 64'd32768) >> 16;
      end
      if (g < K_GAIN_FLOOR) g = K_GAIN_FLOOR;
      model_gain[idx] = g[GAIN_W-1:0];

      // Momentum term, rounded on magnitude with ties away from zero
      vmag  = (vel64 < 0) ? -vel64 : vel64;
      rnd   = (vmag * {48'd0, model_momentum} + 64'd32768) >> 16;
      mterm = (vel64 < 0) ? -$signed(rnd) : $signed(rnd);

      // Step term: eta*gain first, then times the gradient
      eg   = ({48'd0, model_rate} * g + 64'd128) >> 8;
      gmag = (grad64 < 0) ? -grad64 : grad64;
      rnd  = (eg * gmag + 64'd32768) >> 16;
      step = (grad64 < 0) ? -$signed(rnd) : $signed(rnd);

      nv = clip32(mterm - step, sat);
      model_vel[idx] = nv[POS_W-1:0];
      np = clip32(model_pos[idx] + nv, sat);
      model_pos[idx] = np[POS_W-1:0];
    end
    res.position = model_pos[idx];
    res.gain     = model_gain[idx];
    res.sat      = sat;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("mismatch at result %0d, %s: got %h, expected %h",
               result_count, what, got, want);
  endtask

  // Compare each result transfer with the oldest pending prediction
  always @(posedge clk) begin : check_results
    update_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_updates.size() == 0) begin
        report_mismatch("result with nothing pending", out_new_position, 32'd0);
      end else begin
        want = pending_updates.pop_front();
        if (out_new_position !== want.position)
          report_mismatch("new_position", out_new_position, want.position);
        if (out_new_gain !== want.gain)
          report_mismatch("new_gain", {8'd0, out_new_gain}, {8'd0, want.gain});
        if (out_saturated !== want.sat)
          report_mismatch("saturated", {31'd0, out_saturated}, {31'd0, want.sat});
      end
      result_count++;
    end
  end

  // Give up when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver: hold off for a counted stretch when asked, else stall at random
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers; every task is entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // Offer one item, hold it until the transfer, then predict its result
  task automatic send_item(input op_t op, input logic [IDX_W-1:0] idx,
                           input logic signed [POS_W-1:0] operand);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_op            = op;
    in_element_index = idx;
    in_operand_value = operand;
    in_valid         = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_updates.push_back(predict_entry_update(op, idx, operand));
    if (op == OP_LOAD && !entry_loaded[idx]) begin
      entry_loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Wait until every predicted result has arrived, then let the block settle
  task automatic wait_for_drain();
    while (pending_updates.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input cfg_reg_t which, input logic [CFG_W-1:0] value);
    wait_for_drain();
    cfg_index = which;
    cfg_data  = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    case (which)
      REG_MOMENTUM:      model_momentum = value;
      REG_LEARNING_RATE: model_rate     = value;
      default:           ;
    endcase
  endtask

  function automatic logic signed [POS_W-1:0] pick_extreme();
    case ($urandom_range(4))
      0:       return 32'sd0;
      1:       return 32'sd1;
      2:       return -32'sd1;
      3:       return 32'h7FFF_FFFF;
      default: return 32'h8000_0000;
    endcase
  endfunction

  // Mostly modest gradients so the update does not clip every time
  function automatic logic signed [POS_W-1:0] random_gradient();
    int unsigned r;
    logic [31:0] m;
    r = $urandom_range(99);
    if (r < 10) return $urandom;
    if (r < 16) return pick_extreme();
    m = $urandom >> $urandom_range(31, 8);
    return $urandom_range(1) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [POS_W-1:0] random_position();
    int unsigned r;
    logic [31:0] m;
    r = $urandom_range(99);
    if (r < 15) return $urandom;
    if (r < 20) return pick_extreme();
    m = $urandom >> $urandom_range(24, 4);
    return $urandom_range(1) ? -$signed(m) : $signed(m);
  endfunction

  // One random item: a quarter loads, the rest applies to loaded entries,
  // mostly on a small hot set so the same entry comes back to back
  task automatic send_random_item();
    logic [IDX_W-1:0] idx;
    if (loaded_list.size() == 0 || $urandom_range(99) < 25) begin
      if ($urandom_range(1))
        idx = hot_index[$urandom_range(HOT_N-1)];
      else
        idx = IDX_W'($urandom_range(ELEMENTS-1));
      send_item(OP_LOAD, idx, random_position());
    end else begin
      idx = hot_index[$urandom_range(HOT_N-1)];
      if (!entry_loaded[idx] || $urandom_range(99) < 30)
        idx = loaded_list[$urandom_range(loaded_list.size()-1)];
      send_item(OP_APPLY, idx, random_gradient());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, both operations, clipping and reload, at reset registers
  task automatic test_directed_extremes();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    send_item(OP_LOAD, 12'd0, 32'h7FFF_FFFF);
    send_item(OP_LOAD, 12'd4095, 32'h8000_0000);
    send_item(OP_LOAD, 12'd1, 32'sd0);
    send_item(OP_LOAD, 12'd2, 32'h0001_0000);
    // zero gradient on zero velocity: signs agree, gain decays
    send_item(OP_APPLY, 12'd2, 32'sd0);
    send_item(OP_APPLY, 12'd2, 32'sd0);
    // signs disagree, gain grows; then a negative gradient agrees and it decays
    send_item(OP_APPLY, 12'd2, 32'sd655);
    send_item(OP_APPLY, 12'd2, 32'sd655);
    send_item(OP_APPLY, 12'd2, -32'sd655);
    // position clips at the top
    send_item(OP_APPLY, 12'd0, -32'sd65536);
    // velocity and position clip at the bottom, then velocity at the top
    send_item(OP_APPLY, 12'd4095, 32'h7FFF_FFFF);
    send_item(OP_APPLY, 12'd4095, 32'h8000_0000);
    // smallest gradients exercise rounding
    send_item(OP_APPLY, 12'd1, 32'sd1);
    send_item(OP_APPLY, 12'd1, -32'sd1);
    send_item(OP_LOAD, 12'd1, -32'sd1);
    send_item(OP_APPLY, 12'd1, 32'h0000_8000);
    // same entry back to back
    send_item(OP_APPLY, 12'd2, 32'sd123456);
    send_item(OP_APPLY, 12'd2, -32'sd98765);
    send_item(OP_APPLY, 12'd2, 32'sd7);
    // reload after updates drops velocity and gain
    send_item(OP_LOAD, 12'd2, 32'h1234_5678);
    send_item(OP_APPLY, 12'd2, 32'hFFFF_0000);
    send_item(OP_LOAD, 12'd2730, 32'h5555_AAAA);
    send_item(OP_APPLY, 12'd2730, 32'h2AAA_5555);
  endtask

  // Repeated zero gradients decay the gain down to its floor
  task automatic test_gain_floor();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(OP_LOAD, 12'd100, 32'sd0);
    repeat (25) send_item(OP_APPLY, 12'd100, 32'sd0);
    send_item(OP_APPLY, 12'd100, 32'sd655);
  endtask

  // With no momentum a small positive gradient keeps velocity negative,
  // so every apply grows the gain
  task automatic test_gain_growth();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_register(REG_MOMENTUM, 16'd0);
    send_item(OP_LOAD, 12'd200, 32'sd0);
    repeat (40) send_item(OP_APPLY, 12'd200, 32'sd1);
  endtask

  task automatic test_random_phase(input int count, input int send_pct, input int recv_pct,
                                   input logic [CFG_W-1:0] momentum,
                                   input logic [CFG_W-1:0] rate);
    write_register(REG_MOMENTUM, momentum);
    write_register(REG_LEARNING_RATE, rate);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) send_random_item();
  endtask

  // Hold the receiver off while the sender keeps offering, so the block fills
  // and stalls its input
  task automatic test_backpressure();
    wait_for_drain();
    send_idle_pct  = 0;
    recv_stall_pct = 30;
    hold_left      = 400;
    repeat (40) send_random_item();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_op            = OP_LOAD;
    in_element_index = '0;
    in_operand_value = '0;
    out_stall        = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_MOMENTUM;
    cfg_data         = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_left        = 0;
    err_count        = 0;
    result_count     = 0;
    model_momentum   = MOMENTUM_RST;
    model_rate       = LRATE_RST;
    for (int i = 0; i < HOT_N; i++) hot_index[i] = IDX_W'($urandom_range(ELEMENTS-1));

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed_extremes();
    test_gain_floor();
    test_gain_growth();
    test_random_phase(100, 0, 0, MOMENTUM_RST, LRATE_RST);
    test_random_phase(100, 77, 0, 16'hFFFF, 16'h0000);
    test_random_phase(100, 0, 77, 16'h0000, 16'hFFFF);
    test_random_phase(100, 35, 35, CFG_W'($urandom_range(65535)),
                      CFG_W'($urandom_range(65535)));
    test_backpressure();

    wait_for_drain();
    if (pending_updates.size() != 0)
      report_mismatch("results never delivered", pending_updates.size(), 32'd0);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
